@@ rtl/lpt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser plane triangulation package
// Widths, register indexes and the divider step shared by the pipeline.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int DEN_W      = 49;
  localparam int NUM_W      = 48;
  localparam int RAY_W      = 32;
  localparam int PROD_W     = NUM_W + RAY_W;
  localparam int QUO_W      = 41;
  localparam int CAM_W      = 40;
  localparam int TILT_FRAC  = 14;
  localparam int PIPE_DEPTH = 11 + QUO_W;

  typedef enum logic [2:0] {
    REG_FOCAL_X     = 3'd0,
    REG_FOCAL_Y     = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_TILT_COSINE = 3'd4,
    REG_TILT_SINE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] low;
    logic             neg;
    logic             big;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]  lane;
    logic [DEN_W-1:0] den;
    logic             zero;
    logic [15:0]      cos_v;
    logic [15:0]      sin_v;
  } div_t;

  typedef struct packed {
    logic        clipped;
    logic        hit;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } result_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           ge;
    div_lane_t      r;
    t  = {l.rem, l.low[QUO_W-1]};
    ge = (t >= {1'b0, den});
    r  = l;
    r.rem = ge ? DEN_W'(t - {1'b0, den}) : t[DEN_W-1:0];
    r.quo = {l.quo[QUO_W-2:0], ge};
    r.low = {l.low[QUO_W-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [32:0] sat32(logic signed [43:0] v);
    logic [32:0] r;
    if (v > 44'sh0007FFFFFFF) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < -44'sh00080000000) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/laser_plane_triangulation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Laser plane triangulation
// Intersects the pinhole ray of an image point with a laser plane and
// rotates the hit point into world axes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Content
//  s_*      in         image point, plane normal, plane point
//  m_*      out        world x, y, z; hit and clipped flags
//  cfg_*    in         focal lengths, principal point, tilt cosine and sine
//
// One item enters per cycle while the skid entry is empty; on its way each
// result passes the 41 stages of the restoring divider, one quotient bit each.
// Reset is synchronous, clears the valid bits and loads the register reset values.
// A result that cannot leave is held in the output register with one skid
// entry behind it; the pipeline freezes only while the skid entry is full.
// ----------------------------------------------------------------------------
module laser_plane_triangulation (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pixel_col, pixel_row, plane_normal_x/y/z, plane_point_x/y/z
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // world_x, world_y, world_z
  output logic [95:0]  m_tdata,
  // hit, clipped
  output logic [1:0]   m_tuser,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] focal_x, focal_y, center_x, center_y, tilt_cosine, tilt_sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= 16'd6287;
      focal_y     <= 16'd6284;
      center_x    <= 16'd5058;
      center_y    <= 16'd3976;
      tilt_cosine <= 16'd14189;
      tilt_sine   <= 16'd8192;
    end else if (cfg_write) begin
      unique case (lpt_pkg::cfg_reg_t'(cfg_index))
        lpt_pkg::REG_FOCAL_X:     focal_x     <= cfg_data;
        lpt_pkg::REG_FOCAL_Y:     focal_y     <= cfg_data;
        lpt_pkg::REG_CENTER_X:    center_x    <= cfg_data;
        lpt_pkg::REG_CENTER_Y:    center_y    <= cfg_data;
        lpt_pkg::REG_TILT_COSINE: tilt_cosine <= cfg_data;
        lpt_pkg::REG_TILT_SINE:   tilt_sine   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                             en;
  logic [lpt_pkg::PIPE_DEPTH-1:0]   vld;
  logic                             skid_v;
  lpt_pkg::result_t                 skid, res;

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[lpt_pkg::PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // Ray and plane terms.
  logic [15:0]        fx_eff, fy_eff;
  logic signed [16:0] dcol, drow;
  logic [31:0]        a_r0;
  logic signed [33:0] a_r1, a_r2;
  logic signed [15:0] a_n [3];
  logic signed [31:0] a_o [3];
  logic [15:0]        a_c, a_s;

  assign fx_eff = (focal_x == 16'd0) ? 16'd1 : focal_x;
  assign fy_eff = (focal_y == 16'd0) ? 16'd1 : focal_y;
  assign dcol   = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, center_x});
  assign drow   = $signed({1'b0, s_tdata[31:16]}) - $signed({1'b0, center_y});

  always_ff @(posedge clk) begin
    if (en) begin
      a_r0   <= fx_eff * fy_eff;
      a_r1   <= -(34'(drow) * 34'($signed({1'b0, fx_eff})));
      a_r2   <= 34'(dcol) * 34'($signed({1'b0, fy_eff}));
      a_n[0] <= s_tdata[47:32];
      a_n[1] <= s_tdata[63:48];
      a_n[2] <= s_tdata[79:64];
      a_o[0] <= s_tdata[111:80];
      a_o[1] <= s_tdata[143:112];
      a_o[2] <= s_tdata[175:144];
      a_c    <= tilt_cosine;
      a_s    <= tilt_sine;
    end
  end

  logic signed [49:0] b_dt [3];
  logic signed [47:0] b_nt [3];
  logic signed [33:0] b_ray [3];
  logic [15:0]        b_c, b_s;

  always_ff @(posedge clk) begin
    if (en) begin
      b_dt[0]  <= 50'(a_n[0]) * 50'($signed({2'b0, a_r0}));
      b_dt[1]  <= 50'(a_n[1]) * 50'(a_r1);
      b_dt[2]  <= 50'(a_n[2]) * 50'(a_r2);
      b_ray[0] <= $signed({2'b0, a_r0});
      b_ray[1] <= a_r1;
      b_ray[2] <= a_r2;
      for (int i = 0; i < 3; i++) begin
        b_nt[i] <= 48'(a_n[i]) * 48'(a_o[i]);
      end
      b_c <= a_c;
      b_s <= a_s;
    end
  end

  logic signed [49:0] c_den;
  logic signed [48:0] c_num;
  logic signed [33:0] c_ray [3];
  logic [15:0]        c_c, c_s;

  always_ff @(posedge clk) begin
    if (en) begin
      c_den <= b_dt[0] + b_dt[1] + b_dt[2];
      c_num <= 49'(b_nt[0]) + 49'(b_nt[1]) + 49'(b_nt[2]);
      c_ray <= b_ray;
      c_c   <= b_c;
      c_s   <= b_s;
    end
  end

  logic [lpt_pkg::DEN_W-1:0] d_den;
  logic [lpt_pkg::NUM_W-1:0] d_num;
  logic [lpt_pkg::RAY_W-1:0] d_ray [3];
  logic [2:0]                d_neg;
  logic                      d_zero;
  logic [15:0]               d_c, d_s;

  always_ff @(posedge clk) begin
    if (en) begin
      d_den  <= c_den[49] ? lpt_pkg::DEN_W'(-c_den) : c_den[lpt_pkg::DEN_W-1:0];
      d_num  <= c_num[48] ? lpt_pkg::NUM_W'(-c_num) : c_num[lpt_pkg::NUM_W-1:0];
      d_zero <= (c_den == 50'sd0);
      for (int i = 0; i < 3; i++) begin
        d_ray[i] <= c_ray[i][33] ? lpt_pkg::RAY_W'(-c_ray[i])
                                 : c_ray[i][lpt_pkg::RAY_W-1:0];
        d_neg[i] <= c_num[48] ^ c_ray[i][33] ^ c_den[49];
      end
      d_c <= c_c;
      d_s <= c_s;
    end
  end

  logic [63:0]               e_plo [3];
  logic [47:0]               e_phi [3];
  logic [lpt_pkg::DEN_W-1:0] e_den;
  logic [2:0]                e_neg;
  logic                      e_zero;
  logic [15:0]               e_c, e_s;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_plo[i] <= 64'(d_num[31:0]) * 64'(d_ray[i]);
        e_phi[i] <= 48'(d_num[47:32]) * 48'(d_ray[i]);
      end
      e_den  <= d_den;
      e_neg  <= d_neg;
      e_zero <= d_zero;
      e_c    <= d_c;
      e_s    <= d_s;
    end
  end

  logic [lpt_pkg::PROD_W-1:0] f_prod [3];
  logic [lpt_pkg::DEN_W-1:0]  f_den;
  logic [2:0]                 f_neg;
  logic                       f_zero;
  logic [15:0]                f_c, f_s;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_prod[i] <= {e_phi[i], 32'b0} + {16'b0, e_plo[i]};
      end
      f_den  <= e_den;
      f_neg  <= e_neg;
      f_zero <= e_zero;
      f_c    <= e_c;
      f_s    <= e_s;
    end
  end

  // Restoring divider, one quotient bit per stage.
  lpt_pkg::div_t dv [lpt_pkg::QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv[0].lane[i].rem <= {10'b0, f_prod[i][lpt_pkg::PROD_W-1:lpt_pkg::QUO_W]};
        dv[0].lane[i].low <= f_prod[i][lpt_pkg::QUO_W-1:0];
        dv[0].lane[i].quo <= '0;
        dv[0].lane[i].neg <= f_neg[i];
        dv[0].lane[i].big <= ({10'b0, f_prod[i][lpt_pkg::PROD_W-1:lpt_pkg::QUO_W]}
                              >= f_den);
      end
      dv[0].den   <= f_den;
      dv[0].zero  <= f_zero;
      dv[0].cos_v <= f_c;
      dv[0].sin_v <= f_s;
    end
  end

  for (genvar k = 0; k < lpt_pkg::QUO_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv[k+1].lane[i] <= lpt_pkg::div_step(dv[k].lane[i], dv[k].den);
        end
        dv[k+1].den   <= dv[k].den;
        dv[k+1].zero  <= dv[k].zero;
        dv[k+1].cos_v <= dv[k].cos_v;
        dv[k+1].sin_v <= dv[k].sin_v;
      end
    end
  end

  logic [lpt_pkg::QUO_W:0] r_q [3];
  logic [2:0]              r_neg, r_big;
  logic                    r_zero;
  logic [15:0]             r_c, r_s;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i]   <= {1'b0, dv[lpt_pkg::QUO_W].lane[i].quo}
                  + (lpt_pkg::QUO_W+1)'({dv[lpt_pkg::QUO_W].lane[i].rem, 1'b0}
                                        >= {1'b0, dv[lpt_pkg::QUO_W].den});
        r_neg[i] <= dv[lpt_pkg::QUO_W].lane[i].neg;
        r_big[i] <= dv[lpt_pkg::QUO_W].lane[i].big;
      end
      r_zero <= dv[lpt_pkg::QUO_W].zero;
      r_c    <= dv[lpt_pkg::QUO_W].cos_v;
      r_s    <= dv[lpt_pkg::QUO_W].sin_v;
    end
  end

  localparam logic [lpt_pkg::QUO_W:0] CamLim = (lpt_pkg::QUO_W+1)'(1) << (lpt_pkg::CAM_W-1);

  logic [2:0]                       k_ovf;
  logic signed [lpt_pkg::CAM_W-1:0] k_cam_next [3];
  logic signed [lpt_pkg::CAM_W-1:0] k_cam [3];
  logic                             k_clip, k_zero;
  logic signed [15:0]               k_c, k_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_ovf[i] = r_big[i] || (r_neg[i] ? (r_q[i] > CamLim) : (r_q[i] >= CamLim));
      if (k_ovf[i]) begin
        k_cam_next[i] = r_neg[i] ? {1'b1, {(lpt_pkg::CAM_W-1){1'b0}}}
                                 : {1'b0, {(lpt_pkg::CAM_W-1){1'b1}}};
      end else begin
        k_cam_next[i] = r_neg[i] ? lpt_pkg::CAM_W'(-r_q[i])
                                 : r_q[i][lpt_pkg::CAM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_cam  <= k_cam_next;
      k_clip <= |k_ovf;
      k_zero <= r_zero;
      k_c    <= r_c;
      k_s    <= r_s;
    end
  end

  logic signed [40:0]               wy, wz;
  logic signed [56:0]               w_p [4];
  logic signed [lpt_pkg::CAM_W-1:0] w_x;
  logic                             w_clip, w_zero;

  assign wy = -(41'(k_cam[1]));
  assign wz = 41'(k_cam[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      w_p[0] <= 57'(k_c) * 57'(wy);
      w_p[1] <= 57'(k_s) * 57'(wz);
      w_p[2] <= 57'(k_c) * 57'(wz);
      w_p[3] <= 57'(k_s) * 57'(wy);
      w_x    <= k_cam[2];
      w_clip <= k_clip;
      w_zero <= k_zero;
    end
  end

  logic signed [57:0] sy, sz;
  logic [32:0]        sat_x, sat_y, sat_z;
  lpt_pkg::result_t   res_next;

  assign sy    = 58'(w_p[0]) + 58'(w_p[1]) + 58'sd8192;
  assign sz    = 58'(w_p[2]) - 58'(w_p[3]) + 58'sd8192;
  assign sat_x = lpt_pkg::sat32(44'(w_x));
  assign sat_y = lpt_pkg::sat32(sy[57:lpt_pkg::TILT_FRAC]);
  assign sat_z = lpt_pkg::sat32(sz[57:lpt_pkg::TILT_FRAC]);

  always_comb begin
    if (w_zero) begin
      res_next = '0;
    end else begin
      res_next.x       = sat_x[31:0];
      res_next.y       = sat_y[31:0];
      res_next.z       = sat_z[31:0];
      res_next.hit     = 1'b1;
      res_next.clipped = w_clip | sat_x[32] | sat_y[32] | sat_z[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // Output register with one skid entry.
  logic             arrive;
  lpt_pkg::result_t out_r;

  assign arrive = en && vld[lpt_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (m_tvalid && !m_tready) begin
      if (arrive) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      skid_v   <= 1'b0;
      m_tvalid <= 1'b1;
    end else begin
      m_tvalid <= arrive;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && !m_tready) begin
      if (arrive) begin
        skid <= res;
      end
    end else if (skid_v) begin
      out_r <= skid;
    end else if (arrive) begin
      out_r <= res;
    end
  end

  assign m_tdata = {out_r.z, out_r.y, out_r.x};
  assign m_tuser = {out_r.clipped, out_r.hit};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid)
    else $error("Skid entry full while the output register is empty.");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(m_tvalid && !m_tready))
    else $error("Skid entry filled without a stalled output.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == 96'd0) && !m_tuser[1])
    else $error("A miss result carries nonzero fields.");
`endif

endmodule
